// File: design/bdlp_pkg.sv
// Shared types and constants for the button debouncer with long-press detection.
package bdlp_pkg;

  localparam int unsigned DebounceW = 8;
  localparam int unsigned LongW     = 16;
  localparam int unsigned CountW    = 16;
  localparam int unsigned AddrW     = 3;
  localparam int unsigned DataW     = 32;

  localparam logic [DebounceW-1:0] DebounceRst = 8'd10;
  localparam logic [LongW-1:0]     LongRst     = 16'd1500;
  localparam logic [DebounceW-1:0] QualifyMax  = '1;

  typedef enum logic [0:0] {
    RegDebounce = 1'b0,
    RegLong     = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    PhInit     = 3'd0,
    PhWait     = 3'd1,
    PhQualify  = 3'd2,
    PhHeld     = 3'd3,
    PhReleased = 3'd4
  } phase_e;

  typedef struct packed {
    logic [DebounceW-1:0] debounce_ticks;
    logic [LongW-1:0]     long_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic              short_press;
    logic              long_press;
    logic [CountW-1:0] press_count;
    logic              held;
  } result_t;

endpackage

// File: design/bdlp_regs.sv
// Configuration register file behind the APB-style port.
module bdlp_regs
  import bdlp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [DataW-1:0] pwdata_i,
  output logic [DataW-1:0] prdata_o,
  output logic             pready_o,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i & penable_i & pwrite_i;
  assign idx      = reg_idx_e'(paddr_i[2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegDebounce: cfg_d.debounce_ticks   = pwdata_i[DebounceW-1:0];
        RegLong:     cfg_d.long_press_ticks = pwdata_i[LongW-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegDebounce: prdata_o = {{(DataW-DebounceW){1'b0}}, cfg_q.debounce_ticks};
      RegLong:     prdata_o = {{(DataW-LongW){1'b0}}, cfg_q.long_press_ticks};
      default:     prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks   <= DebounceRst;
      cfg_q.long_press_ticks <= LongRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/bdlp_core.sv
// Phase machine, qualify and hold counters, and press counter, one tick per transaction.
module bdlp_core
  import bdlp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  logic    pin_level_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  phase_e               phase_q, phase_d;
  logic [DebounceW-1:0] qual_q, qual_d;
  logic [LongW-1:0]     hold_q, hold_d;
  logic [CountW-1:0]    presses_q, presses_d;
  logic [DebounceW-1:0] qual_inc;
  logic [LongW:0]       hold_inc;
  logic                 short_ev, long_ev;

  assign qual_inc = (qual_q == QualifyMax) ? qual_q : qual_q + 1'b1;
  assign hold_inc = {1'b0, hold_q} + 1'b1;

  always_comb begin
    phase_d   = phase_q;
    qual_d    = qual_q;
    hold_d    = hold_q;
    presses_d = presses_q;
    short_ev  = 1'b0;
    long_ev   = 1'b0;
    case (phase_q)
      PhWait: begin
        if (pin_level_i) begin
          qual_d  = '0;
          phase_d = PhQualify;
        end
      end
      PhQualify: begin
        qual_d = qual_inc;
        if (!pin_level_i) begin
          phase_d = PhWait;
        end else if (qual_inc >= cfg_i.debounce_ticks) begin
          phase_d = PhHeld;
        end
      end
      PhHeld: begin
        if (hold_inc > {1'b0, cfg_i.long_press_ticks}) begin
          hold_d = cfg_i.long_press_ticks;
        end else begin
          hold_d = hold_inc[LongW-1:0];
        end
        if (!pin_level_i) begin
          phase_d = PhReleased;
        end
      end
      PhReleased: begin
        presses_d = presses_q + 1'b1;
        if (hold_q < cfg_i.long_press_ticks) begin
          short_ev = 1'b1;
        end else begin
          long_ev = 1'b1;
        end
        hold_d  = '0;
        phase_d = PhWait;
      end
      default: begin
        presses_d = '0;
        qual_d    = '0;
        hold_d    = '0;
        phase_d   = PhWait;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhInit;
      qual_q    <= '0;
      hold_q    <= '0;
      presses_q <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      qual_q    <= qual_d;
      hold_q    <= hold_d;
      presses_q <= presses_d;
    end
  end

  assign res_o.short_press = short_ev;
  assign res_o.long_press  = long_ev;
  assign res_o.press_count = presses_d;
  assign res_o.held        = (phase_d == PhHeld);

endmodule

// File: design/bdlp_outbuf.sv
// Result register with a skid stage.
module bdlp_outbuf
  import bdlp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  logic    out_v_q, out_v_d;
  logic    skid_v_q, skid_v_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop     = out_v_q & ready_i;
  assign ready_o = ~skid_v_q;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (!out_v_q || pop) begin
      out_v_d  = skid_v_q | push_i;
      out_d    = skid_v_q ? skid_q : data_i;
      skid_v_d = 1'b0;
    end else if (push_i) begin
      skid_v_d = 1'b1;
      skid_d   = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign valid_o = out_v_q;
  assign data_o  = out_q;

endmodule

// File: design/button_debounce_long_press_top.sv
// Top level of the button debouncer with short and long press detection.
//
//   port group   direction  handshake                      payload
//   in           sink       in_valid_i / in_ready_o        pin_level_i
//   out          source     out_valid_o / out_ready_i      short_press_o, long_press_o,
//                                                          press_count_o, held_o
//   apb          sink       psel/penable/pwrite, pready     paddr, pwdata, prdata
//
// One transaction per cycle while in_ready_o is high; its result is registered in the result
// register, or in the skid stage while the output stalls. The phase and counter step is a
// single combinational pass into the result register. Reset puts the machine in its init
// phase and loads the default tick counts. A skid stage behind the result register takes one
// more result while the output stalls; in_ready_o drops only when both output stages hold results.
module button_debounce_long_press_top
  import bdlp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              pin_level_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              short_press_o,
  output logic              long_press_o,
  output logic [CountW-1:0] press_count_o,
  output logic              held_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  cfg_t    cfg;
  result_t step_res;
  result_t out_res;
  logic    push;

  assign push = in_valid_i & in_ready_o;

  bdlp_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  bdlp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (push),
    .pin_level_i (pin_level_i),
    .cfg_i       (cfg),
    .res_o       (step_res)
  );

  bdlp_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (step_res),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_res)
  );

  assign short_press_o = out_res.short_press;
  assign long_press_o  = out_res.long_press;
  assign press_count_o = out_res.press_count;
  assign held_o        = out_res.held;

endmodule

// File: bench/tb_button_debounce_long_press_top.sv
// Self-checking testbench for the button debouncer with short and long press detection.
`timescale 1ns / 1ps

module tb_button_debounce_long_press_top;
  import bdlp_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned RandomItems = 450;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              pin_level_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              short_press_o;
  logic              long_press_o;
  logic [CountW-1:0] press_count_o;
  logic              held_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  button_debounce_long_press_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pin_level_i   (pin_level_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .short_press_o (short_press_o),
    .long_press_o  (long_press_o),
    .press_count_o (press_count_o),
    .held_o        (held_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Debouncer state and configuration as predicted
  phase_e               ph = PhInit;
  logic [DebounceW-1:0] qual_cnt = '0;
  logic [LongW-1:0]     hold_cnt = '0;
  logic [CountW-1:0]    press_cnt = '0;
  logic [DebounceW-1:0] deb_ticks = DebounceRst;
  logic [LongW-1:0]     long_ticks = LongRst;

  logic        level_q[$];
  result_t     expected_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned rand_items = 0;

  function automatic result_t debounce_step(input logic level);
    result_t        r;
    logic [LongW:0] nxt;
    r = '0;
    case (ph)
      PhWait: begin
        if (level) begin
          qual_cnt = '0;
          ph = PhQualify;
        end
      end
      PhQualify: begin
        if (qual_cnt != QualifyMax) qual_cnt = qual_cnt + 1'b1;
        if (!level) ph = PhWait;
        else if (qual_cnt >= deb_ticks) ph = PhHeld;
      end
      PhHeld: begin
        nxt = {1'b0, hold_cnt} + 1'b1;
        if (nxt > {1'b0, long_ticks}) nxt = {1'b0, long_ticks};
        hold_cnt = nxt[LongW-1:0];
        if (!level) ph = PhReleased;
      end
      PhReleased: begin
        press_cnt = press_cnt + 1'b1;
        if (hold_cnt < long_ticks) r.short_press = 1'b1;
        else r.long_press = 1'b1;
        hold_cnt = '0;
        ph = PhWait;
      end
      default: begin
        press_cnt = '0;
        qual_cnt = '0;
        hold_cnt = '0;
        ph = PhWait;
      end
    endcase
    r.press_count = press_cnt;
    r.held = (ph == PhHeld);
    return r;
  endfunction

  // Sender: bursts of transactions with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt_valid;
    logic nxt_level;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      pin_level_i <= 1'b0;
    end else begin
      nxt_valid = in_valid_i;
      nxt_level = pin_level_i;
      if (in_valid_i && in_ready_o) begin
        expected_q.push_back(debounce_step(pin_level_i));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (level_q.size() != 0) begin
          nxt_valid = 1'b1;
          nxt_level = level_q.pop_front();
          if (burst_left != 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
          end
        end
      end
      in_valid_i <= nxt_valid;
      pin_level_i <= nxt_level;
    end
  end

  // Receiver: checks each result against the prediction, under a stall mode picked at random
  int unsigned stall_mode = 0;
  logic [7:0]  stall_pat = 8'hff;

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected transaction short=%0b long=%0b count=%0d held=%0b",
                   $time, short_press_o, long_press_o, press_count_o, held_o);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (short_press_o !== exp_r.short_press) begin
            $display("%0t: short_press expected %0b actual %0b",
                     $time, exp_r.short_press, short_press_o);
            errors++;
          end
          if (long_press_o !== exp_r.long_press) begin
            $display("%0t: long_press expected %0b actual %0b",
                     $time, exp_r.long_press, long_press_o);
            errors++;
          end
          if (press_count_o !== exp_r.press_count) begin
            $display("%0t: press_count expected %0d actual %0d",
                     $time, exp_r.press_count, press_count_o);
            errors++;
          end
          if (held_o !== exp_r.held) begin
            $display("%0t: held expected %0b actual %0b", $time, exp_r.held, held_o);
            errors++;
          end
        end
      end
      if (cycles % 300 == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_pat = 8'($urandom);
      end
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= stall_pat[cycles % 8];
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic reg_write(input reg_idx_e idx, input logic [DataW-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == RegDebounce) deb_ticks = val[DebounceW-1:0];
    else long_ticks = val[LongW-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic push_run(input logic level, input int unsigned n);
    repeat (n) level_q.push_back(level);
  endtask

  task automatic drain();
    while (level_q.size() != 0 || in_valid_i || expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_press();
    int unsigned hold_len;
    repeat ($urandom_range(0, 2)) begin
      push_run(1'b1, $urandom_range(1, (deb_ticks > 1) ? deb_ticks - 1 : 1));
      push_run(1'b0, $urandom_range(1, 3));
    end
    hold_len = $urandom_range(0, 2 * long_ticks + 3);
    if (hold_len > 80) hold_len = $urandom_range(0, 80);
    push_run(1'b1, deb_ticks + 1 + hold_len);
    push_run(1'b0, $urandom_range(1, 4));
    rand_items += deb_ticks + hold_len + 6;
  endtask

  initial begin
    int unsigned      n;
    logic [DataW-1:0] val;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: short press at the default debounce count
    push_run(1'b0, 1);
    push_run(1'b1, 11);
    push_run(1'b0, 2);
    drain();

    // Bounce, short press, long press with saturation
    reg_write(RegDebounce, 32'd1);
    reg_write(RegLong, 32'd3);
    push_run(1'b1, 1);
    push_run(1'b0, 1);
    push_run(1'b1, 3);
    push_run(1'b0, 2);
    push_run(1'b1, 6);
    push_run(1'b0, 2);
    drain();

    // Zero debounce and zero long limit
    reg_write(RegDebounce, 32'd0);
    reg_write(RegLong, 32'd0);
    push_run(1'b1, 3);
    push_run(1'b0, 2);
    drain();

    // Lower the long limit while held
    reg_write(RegDebounce, 32'd1);
    reg_write(RegLong, 32'd20);
    push_run(1'b1, 6);
    drain();
    reg_write(RegLong, 32'd2);
    push_run(1'b1, 1);
    push_run(1'b0, 2);
    drain();

    // Largest debounce count: one short and one saturated long press
    reg_write(RegDebounce, 32'hffff_ffff);
    reg_write(RegLong, 32'hffff_0020);
    push_run(1'b1, 270);
    push_run(1'b0, 2);
    push_run(1'b1, 256 + 40);
    push_run(1'b0, 2);
    drain();

    while (rand_items < RandomItems) begin
      case ($urandom_range(0, 9))
        0: val = 32'd0;
        1: val = 32'd255;
        2: val = 32'd1;
        default: val = $urandom_range(1, 12);
      endcase
      val[DataW-1:DebounceW] = (DataW-DebounceW)'($urandom);
      reg_write(RegDebounce, val);
      case ($urandom_range(0, 9))
        0: val = 32'd0;
        1: val = 32'd65535;
        2: val = 32'd1;
        default: val = $urandom_range(1, 40);
      endcase
      val[DataW-1:LongW] = (DataW-LongW)'($urandom);
      reg_write(RegLong, val);
      n = (deb_ticks > 100) ? 2 : $urandom_range(3, 10);
      repeat (n) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 10)) level_q.push_back(1'($urandom_range(0, 1)));
          rand_items += 5;
        end else begin
          push_press();
        end
      end
      // end the phase at a random point, sometimes mid-press
      if ($urandom_range(0, 2) == 0) push_run(1'b1, deb_ticks + $urandom_range(1, 6));
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: button_debounce_long_press_top.f
design/bdlp_pkg.sv
design/bdlp_regs.sv
design/bdlp_core.sv
design/bdlp_outbuf.sv
design/button_debounce_long_press_top.sv
bench/tb_button_debounce_long_press_top.sv
